// ===== rtl/cle_pkg.sv =====
// cle_pkg: types, codes and constants shared by the console line editor files
// no dependencies
package cle_pkg;

    localparam int LINE_SIZE_DEF = 32;
    localparam int CHANNELS_DEF  = 2;
    localparam int POS_W         = 6;

    localparam logic [1:0] K_BYTE    = 2'd0;
    localparam logic [1:0] K_RELEASE = 2'd1;
    localparam logic [1:0] K_READ    = 2'd2;

    localparam logic [1:0] RK_ECHO    = 2'd0;
    localparam logic [1:0] RK_READ    = 2'd1;
    localparam logic [1:0] RK_REFUSED = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [1:0]       kind;
        logic             channel;
        logic             echo_channel;
        logic [7:0]       rx_byte;
        logic [POS_W-1:0] read_index;
    } t_in;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic             out_channel;
        logic [7:0]       data;
        logic             line_ready;
        logic [POS_W-1:0] line_length;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [1:0]     cnt;
        logic           use_rd;
        t_out [2:0]     res;
    } t_res_bundle;

    function automatic t_out mk_res(logic [1:0] rk, logic ch, logic [7:0] d,
                                    logic rdy, logic [POS_W-1:0] len, logic lst);
        t_out r;
        r.result_kind = rk;
        r.out_channel = ch;
        r.data        = d;
        r.line_ready  = rdy;
        r.line_length = len;
        r.last        = lst;
        return r;
    endfunction

endpackage

// ===== rtl/cle_line_mem.sv =====
// cle_line_mem: line store, one write port and one registered read port
// depends on nothing but its parameters
module cle_line_mem #(
    parameter int DEPTH = 66,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cle_editor.sv =====
// cle_editor: decodes one request, keeps per-channel position and held length,
// drives the line store ports and builds the result list; uses cle_pkg
module cle_editor
    import cle_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF,
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int AW        = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  t_in           i_req,
    output t_res_bundle   o_bundle,
    output logic          o_pend,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr
);

    localparam logic [POS_W-1:0] LSZ = POS_W'(LINE_SIZE);
    localparam logic [AW-1:0]    ROW = AW'(LINE_SIZE + 1);

    logic [POS_W-1:0] r_wp   [2];
    logic [POS_W-1:0] r_held [2];
    logic             r_pend;
    logic [AW-1:0]    r_pend_addr;

    logic             ch_ok;
    logic             idx_ok;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] npos;
    logic [AW-1:0]    base;
    logic             char_wr;
    logic             term_wr;
    logic             upd;
    logic [POS_W-1:0] n_wp;
    logic [POS_W-1:0] n_held;
    logic [7:0]       c;
    logic             ech;

    assign c      = i_req.rx_byte;
    assign ech    = i_req.echo_channel;
    assign ch_ok  = (CHANNELS > 1) || (i_req.channel == 1'b0);
    assign idx_ok = i_req.read_index <= LSZ;
    assign pos    = (r_wp[i_req.channel] > LSZ) ? LSZ : r_wp[i_req.channel];
    assign base   = i_req.channel ? ROW : '0;

    always_comb begin
        o_bundle = '0;
        char_wr  = 1'b0;
        term_wr  = 1'b0;
        npos     = pos;
        upd      = 1'b0;
        n_wp     = r_wp[i_req.channel];
        n_held   = r_held[i_req.channel];
        case (i_req.kind)
            K_READ: begin
                o_bundle.cnt    = 2'd1;
                o_bundle.use_rd = ch_ok && idx_ok;
                o_bundle.res[0] = mk_res(RK_READ, ech, CH_NUL, 1'b0, '0, 1'b1);
            end
            K_RELEASE: begin
                if (ch_ok) begin
                    upd    = 1'b1;
                    n_wp   = '0;
                    n_held = '0;
                end
            end
            K_BYTE: begin
                if (!ch_ok) begin
                    o_bundle.cnt = 2'd0;
                end else if (r_held[i_req.channel] != '0) begin
                    o_bundle.cnt    = 2'd1;
                    o_bundle.res[0] = mk_res(RK_REFUSED, ech, c, 1'b0, '0, 1'b1);
                end else if (c == CH_NUL || c == CH_LF) begin
                    o_bundle.cnt = 2'd0;
                end else if (c == CH_BS) begin
                    if (pos != '0) begin
                        o_bundle.cnt    = 2'd3;
                        o_bundle.res[0] = mk_res(RK_ECHO, ech, CH_BS, 1'b0, '0, 1'b0);
                        o_bundle.res[1] = mk_res(RK_ECHO, ech, CH_SP, 1'b0, '0, 1'b0);
                        o_bundle.res[2] = mk_res(RK_ECHO, ech, CH_BS, 1'b0, '0, 1'b1);
                        upd             = 1'b1;
                        n_wp            = pos - 1'b1;
                    end
                end else if (c == CH_CR) begin
                    o_bundle.cnt    = 2'd2;
                    o_bundle.res[0] = mk_res(RK_ECHO, ech, CH_CR, 1'b0, '0, 1'b0);
                    o_bundle.res[1] = mk_res(RK_ECHO, ech, CH_LF, 1'b1, pos, 1'b1);
                    term_wr         = 1'b1;
                    upd             = 1'b1;
                    n_wp            = pos;
                    n_held          = pos;
                end else begin
                    if (pos < LSZ) begin
                        char_wr = 1'b1;
                        npos    = pos + 1'b1;
                    end
                    if (npos < LSZ) begin
                        o_bundle.cnt    = 2'd1;
                        o_bundle.res[0] = mk_res(RK_ECHO, ech, c, 1'b0, '0, 1'b1);
                        upd             = 1'b1;
                        n_wp            = npos;
                    end else begin
                        // line full: forced completion
                        o_bundle.cnt    = 2'd3;
                        o_bundle.res[0] = mk_res(RK_ECHO, ech, c, 1'b0, '0, 1'b0);
                        o_bundle.res[1] = mk_res(RK_ECHO, ech, CH_CR, 1'b0, '0, 1'b0);
                        o_bundle.res[2] = mk_res(RK_ECHO, ech, CH_LF, 1'b1, npos, 1'b1);
                        term_wr         = 1'b1;
                        upd             = 1'b1;
                        n_wp            = npos;
                        n_held          = npos;
                    end
                end
            end
            default: begin
                o_bundle = '0;
            end
        endcase
    end

    // first write now; the terminator after a stored character is written in the next cycle
    always_comb begin
        o_we    = r_pend || (i_acc && (char_wr || term_wr));
        o_wdata = (!r_pend && char_wr) ? c : CH_NUL;
        if (r_pend) begin
            o_waddr = r_pend_addr;
        end else if (char_wr) begin
            o_waddr = base + AW'(pos);
        end else begin
            o_waddr = base + AW'(npos);
        end
    end

    assign o_re    = i_acc && o_bundle.use_rd;
    assign o_raddr = base + AW'(i_req.read_index);
    assign o_pend  = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_wp[i]   <= '0;
                r_held[i] <= '0;
            end
        end else begin
            r_pend <= i_acc && char_wr && term_wr;
            if (i_acc && upd) begin
                r_wp[i_req.channel]   <= n_wp;
                r_held[i_req.channel] <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= base + AW'(npos);
    end

endmodule

// ===== rtl/cle_result_queue.sv =====
// cle_result_queue: holds the result list of one request and feeds the output register
// uses cle_pkg
module cle_result_queue
    import cle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res_bundle i_bundle,
    input  logic [7:0]  i_rdata,
    output logic        o_can_take,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_req
);

    logic [1:0] r_cnt;
    logic       r_use_rd;
    t_out [2:0] r_res;
    logic       r_out_valid;
    t_out       r_out;

    logic       out_free;
    logic       move;
    t_out       head;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = (r_cnt != 2'd0) && out_free;
    assign o_can_take = (r_cnt == 2'd0) || (move && r_cnt == 2'd1);

    always_comb begin
        head = r_res[0];
        if (r_use_rd) begin
            head.data = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
                r_cnt       <= r_cnt - 2'd1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_cnt <= i_bundle.cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out    <= head;
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
            r_use_rd <= 1'b0;
        end
        if (i_load) begin
            r_res    <= i_bundle.res;
            r_use_rd <= i_bundle.use_rd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ===== rtl/console_line_editor.sv =====
// console_line_editor: top level of the per-channel serial console line editor
// uses cle_pkg, cle_line_mem, cle_editor and cle_result_queue
//
// Input channel: i_in_valid / o_in_stall carrying i_in_req (byte, release or read).
// Output channel: o_out_valid / i_out_stall carrying o_out_req, one result per cycle while i_out_stall is low.
// A request is taken when valid is high and stall is low at a rising clock edge.
// A request gives zero to three results; the final one has last set.
// After a request is taken, its first result goes through the result sequencer
// and then the output register. The sequencer holds one request's list and emits
// one result a cycle while the output is not stalled; the next request is taken in
// the cycle its last result moves to the output register; requests with no result
// or one result go back to back at one per cycle while the output is not stalled.
// A completion that follows a stored character needs a second line store write
// (the terminator) on the single write port in the next cycle; that request has
// three results, so the one-cycle input stall it raises is hidden behind the
// sequencer.
// Reads use the registered read port of the line store; data arrives in the next cycle.
// Reset clears line positions and held lengths; the line store is not cleared.
// While the receiver stalls, the output register and the sequencer fill, after
// which o_in_stall rises; nothing is dropped.
module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_req
);

    localparam int DEPTH = CHANNELS * (LINE_SIZE + 1);
    localparam int AW    = $clog2(DEPTH);

    logic          acc;
    logic          can_take;
    logic          pend;
    t_res_bundle   bundle;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    assign o_in_stall = pend || !can_take;
    assign acc        = i_in_valid && !o_in_stall;

    cle_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cle_editor #(
        .LINE_SIZE (LINE_SIZE),
        .CHANNELS  (CHANNELS),
        .AW        (AW)
    ) u_edit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_req    (i_in_req),
        .o_bundle (bundle),
        .o_pend   (pend),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_re     (re),
        .o_raddr  (raddr)
    );

    cle_result_queue u_rq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (acc),
        .i_bundle    (bundle),
        .i_rdata     (rdata),
        .o_can_take  (can_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    // terminator write owns the write port, no request may enter then
    a_pend_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend |-> o_in_stall)
        else $error("request taken during terminator write");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re))
        else $error("line store read and write in one cycle");

    a_ready_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.line_ready) |->
            (o_out_req.last && o_out_req.data == CH_LF))
        else $error("line ready on a result other than final LF");

endmodule
